>>> rtl/core/c8x_pkg.sv
// Shared types, codes and the font table of the instruction executor.
`default_nettype none
package c8x_pkg;

  localparam int MEM_DEPTH   = 4096;
  localparam int DISP_WIDTH  = 64;
  localparam int DISP_HEIGHT = 32;
  localparam int FONT_BYTES  = 80;
  localparam logic [11:0] PC_RESET = 12'h200;

  typedef struct packed {
    logic [2:0]  mode;
    logic [11:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  rand_byte;
    logic [3:0]  key_code;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] prog_counter;
    logic [63:0] peek_data;
    logic        sound_on;
  } out_t;

  typedef enum logic [2:0] {
    MODE_EXEC  = 3'd0,
    MODE_TICK  = 3'd1,
    MODE_WRITE = 3'd2,
    MODE_READ  = 3'd3,
    MODE_ROW   = 3'd4,
    MODE_KDOWN = 3'd5,
    MODE_KUP   = 3'd6,
    MODE_NONE  = 3'd7
  } mode_t;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_WAIT = 2'd1;
  localparam logic [1:0] ST_HALT = 2'd2;

  localparam logic [3:0] OP_SYS  = 4'h0;
  localparam logic [3:0] OP_JP   = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SEI  = 4'h3;
  localparam logic [3:0] OP_SNEI = 4'h4;
  localparam logic [3:0] OP_SE   = 4'h5;
  localparam logic [3:0] OP_LDI  = 4'h6;
  localparam logic [3:0] OP_ADDI = 4'h7;
  localparam logic [3:0] OP_ALU  = 4'h8;
  localparam logic [3:0] OP_SNE  = 4'h9;
  localparam logic [3:0] OP_LDIX = 4'hA;
  localparam logic [3:0] OP_JPV  = 4'hB;
  localparam logic [3:0] OP_RND  = 4'hC;
  localparam logic [3:0] OP_DRW  = 4'hD;
  localparam logic [3:0] OP_KEY  = 4'hE;
  localparam logic [3:0] OP_MISC = 4'hF;

  localparam logic [7:0] NN_CLS  = 8'he0;
  localparam logic [7:0] NN_RET  = 8'hee;
  localparam logic [7:0] NN_SKP  = 8'h9e;
  localparam logic [7:0] NN_SKNP = 8'ha1;
  localparam logic [7:0] FX_GDT  = 8'h07;
  localparam logic [7:0] FX_WKEY = 8'h0a;
  localparam logic [7:0] FX_SDT  = 8'h15;
  localparam logic [7:0] FX_SST  = 8'h18;
  localparam logic [7:0] FX_ADDI = 8'h1e;
  localparam logic [7:0] FX_FONT = 8'h29;
  localparam logic [7:0] FX_BCD  = 8'h33;
  localparam logic [7:0] FX_STOR = 8'h55;
  localparam logic [7:0] FX_LOAD = 8'h65;

  typedef enum logic [3:0] {
    ALU_MOV  = 4'h0,
    ALU_OR   = 4'h1,
    ALU_AND  = 4'h2,
    ALU_XOR  = 4'h3,
    ALU_ADD  = 4'h4,
    ALU_SUB  = 4'h5,
    ALU_SHR  = 4'h6,
    ALU_SUBN = 4'h7,
    ALU_SHL  = 4'hE
  } alu_op_t;

  function automatic alu_op_t alu_op_of(logic [3:0] n);
    alu_op_t r;
    case (n)
      4'h1: r = ALU_OR;
      4'h2: r = ALU_AND;
      4'h3: r = ALU_XOR;
      4'h4: r = ALU_ADD;
      4'h5: r = ALU_SUB;
      4'h6: r = ALU_SHR;
      4'h7: r = ALU_SUBN;
      4'hE: r = ALU_SHL;
      default: r = ALU_MOV;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] font_byte(logic [6:0] a);
    logic [7:0] r;
    case (a)
      7'd0: r = 8'hf0;  7'd1: r = 8'h90;  7'd2: r = 8'h90;  7'd3: r = 8'h90;
      7'd4: r = 8'hf0;  7'd5: r = 8'h20;  7'd6: r = 8'h60;  7'd7: r = 8'h20;
      7'd8: r = 8'h20;  7'd9: r = 8'h70;  7'd10: r = 8'hf0; 7'd11: r = 8'h10;
      7'd12: r = 8'hf0; 7'd13: r = 8'h80; 7'd14: r = 8'hf0; 7'd15: r = 8'hf0;
      7'd16: r = 8'h10; 7'd17: r = 8'hf0; 7'd18: r = 8'h10; 7'd19: r = 8'hf0;
      7'd20: r = 8'h90; 7'd21: r = 8'h90; 7'd22: r = 8'hf0; 7'd23: r = 8'h10;
      7'd24: r = 8'h10; 7'd25: r = 8'hf0; 7'd26: r = 8'h80; 7'd27: r = 8'hf0;
      7'd28: r = 8'h10; 7'd29: r = 8'hf0; 7'd30: r = 8'hf0; 7'd31: r = 8'h80;
      7'd32: r = 8'hf0; 7'd33: r = 8'h90; 7'd34: r = 8'hf0; 7'd35: r = 8'hf0;
      7'd36: r = 8'h10; 7'd37: r = 8'h20; 7'd38: r = 8'h40; 7'd39: r = 8'h40;
      7'd40: r = 8'hf0; 7'd41: r = 8'h90; 7'd42: r = 8'hf0; 7'd43: r = 8'h90;
      7'd44: r = 8'hf0; 7'd45: r = 8'hf0; 7'd46: r = 8'h90; 7'd47: r = 8'hf0;
      7'd48: r = 8'h10; 7'd49: r = 8'hf0; 7'd50: r = 8'hf0; 7'd51: r = 8'h90;
      7'd52: r = 8'hf0; 7'd53: r = 8'h90; 7'd54: r = 8'h90; 7'd55: r = 8'he0;
      7'd56: r = 8'h90; 7'd57: r = 8'he0; 7'd58: r = 8'h90; 7'd59: r = 8'he0;
      7'd60: r = 8'hf0; 7'd61: r = 8'h80; 7'd62: r = 8'h80; 7'd63: r = 8'h80;
      7'd64: r = 8'hf0; 7'd65: r = 8'he0; 7'd66: r = 8'h90; 7'd67: r = 8'h90;
      7'd68: r = 8'h90; 7'd69: r = 8'he0; 7'd70: r = 8'hf0; 7'd71: r = 8'h80;
      7'd72: r = 8'hf0; 7'd73: r = 8'h80; 7'd74: r = 8'hf0; 7'd75: r = 8'hf0;
      7'd76: r = 8'h80; 7'd77: r = 8'hf0; 7'd78: r = 8'h80; 7'd79: r = 8'h80;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/c8x_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module c8x_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
    rdata <= store[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/core/c8x_alu.sv
// Shared 8-bit arithmetic, logic, shift and compare unit.
`default_nettype none
module c8x_alu import c8x_pkg::*; (
  input  wire alu_op_t    op,
  input  wire logic [7:0] a,
  input  wire logic [7:0] b,
  output      logic [7:0] res,
  output      logic       flag,
  output      logic       eq
);

  logic [8:0] sum;

  assign sum = {1'b0, a} + {1'b0, b};
  assign eq  = (a == b);

  always_comb begin
    res  = b;
    flag = 1'b0;
    case (op)
      ALU_MOV:  res = b;
      ALU_OR:   res = a | b;
      ALU_AND:  res = a & b;
      ALU_XOR:  res = a ^ b;
      ALU_ADD: begin
        res  = sum[7:0];
        flag = sum[8];
      end
      ALU_SUB: begin
        res  = a - b;
        flag = (a >= b);
      end
      ALU_SHR: begin
        res  = {1'b0, a[7:1]};
        flag = a[0];
      end
      ALU_SUBN: begin
        res  = b - a;
        flag = (b >= a);
      end
      ALU_SHL: begin
        res  = {a[6:0], 1'b0};
        flag = a[7];
      end
      default: res = b;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/chip8_instruction_executor_core.sv
// Top level of the instruction executor: sequencer, state registers and memories.
// After reset a clearing pass loads the font and clears all stores; busy is high.
// Non-execute items pass through dispatch, a read wait for peeks and the finish state to done.
// Execute fetches, reads Vx and Vy and executes (only finish when halted or waiting), plus
// a state for flag ALU ops or returns, and loops for sprite rows, register copies, clear, BCD.
// The done strobe lasts one cycle and cannot be stalled; busy stays high until then.
`default_nettype none
module chip8_instruction_executor_core import c8x_pkg::*; #(
  parameter int STACK_DEPTH = 128
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire in_t  cmd,
  output      logic busy,
  output      logic done,
  output      out_t result
);

  localparam int SW = $clog2(STACK_DEPTH);

  typedef enum logic [23:0] {
    S_INIT = 24'd1 << 0,  S_IDLE = 24'd1 << 1,  S_DISP = 24'd1 << 2,
    S_RDW  = 24'd1 << 3,  S_FIN  = 24'd1 << 4,  S_F0   = 24'd1 << 5,
    S_F1   = 24'd1 << 6,  S_F2   = 24'd1 << 7,  S_RX   = 24'd1 << 8,
    S_RY   = 24'd1 << 9,  S_RV   = 24'd1 << 10, S_EXEC = 24'd1 << 11,
    S_ALU2 = 24'd1 << 12, S_CLS  = 24'd1 << 13, S_RET  = 24'd1 << 14,
    S_D0   = 24'd1 << 15, S_D1   = 24'd1 << 16, S_BH   = 24'd1 << 17,
    S_BT   = 24'd1 << 18, S_BW   = 24'd1 << 19, S_ST0  = 24'd1 << 20,
    S_ST1  = 24'd1 << 21, S_LD0  = 24'd1 << 22, S_LD1  = 24'd1 << 23
  } state_t;

  function automatic logic [SW-1:0] smod(logic [6:0] p);
    logic [7:0] r;
    r = 8'd0;
    for (int k = 6; k >= 0; k--) begin
      r = {r[6:0], p[k]};
      if (r >= 8'(STACK_DEPTH)) r = r - 8'(STACK_DEPTH);
    end
    return r[SW-1:0];
  endfunction

  state_t state;
  in_t    req;
  logic [11:0] clr;
  logic [11:0] pc;
  logic [15:0] ireg;
  logic [6:0]  sp;
  logic [7:0]  delay_cnt, sound_cnt;
  logic [15:0] keys;
  logic        key_wait, halt;
  logic [3:0]  wait_x;
  logic [7:0]  ins_hi, ins_lo;
  logic [7:0]  vx, vy;
  logic [4:0]  cnt;
  logic [4:0]  row;
  logic        hit;
  logic [7:0]  val;
  logic [1:0]  hd;
  logic [3:0]  td;
  logic [63:0] rd;

  logic [3:0]  op, xi, yi, ni;
  logic [7:0]  nn;
  logic [11:0] nnn;
  logic [8:0]  ysum;
  logic [63:0] mask;
  logic        key_hit;

  logic        mem_we;
  logic [11:0] mem_waddr, mem_raddr;
  logic [7:0]  mem_wdata, mem_rdata;
  logic        fb_we;
  logic [4:0]  fb_waddr, fb_raddr;
  logic [63:0] fb_wdata, fb_rdata;
  logic          stk_we;
  logic [SW-1:0] stk_waddr, stk_raddr;
  logic [11:0]   stk_wdata, stk_rdata;
  logic        vr_we;
  logic [3:0]  vr_waddr, vr_raddr;
  logic [7:0]  vr_wdata, vr_rdata;

  alu_op_t    alu_op;
  logic [7:0] alu_a, alu_b, alu_res;
  logic       alu_flag, alu_eq;

  c8x_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_mem (
    .clk, .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata));
  c8x_ram #(.WIDTH(DISP_WIDTH), .DEPTH(DISP_HEIGHT)) u_fb (
    .clk, .we(fb_we), .waddr(fb_waddr), .wdata(fb_wdata),
    .raddr(fb_raddr), .rdata(fb_rdata));
  c8x_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stk (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata));
  c8x_ram #(.WIDTH(8), .DEPTH(16)) u_vr (
    .clk, .we(vr_we), .waddr(vr_waddr), .wdata(vr_wdata),
    .raddr(vr_raddr), .rdata(vr_rdata));

  c8x_alu u_alu (.op(alu_op), .a(alu_a), .b(alu_b), .res(alu_res),
    .flag(alu_flag), .eq(alu_eq));

  assign op   = ins_hi[7:4];
  assign xi   = ins_hi[3:0];
  assign yi   = ins_lo[7:4];
  assign ni   = ins_lo[3:0];
  assign nn   = ins_lo;
  assign nnn  = {ins_hi[3:0], ins_lo};
  assign ysum = {1'b0, vy} + {4'b0, cnt};
  assign mask = {mem_rdata, 56'b0} >> vx;
  assign key_hit = (vx[7:4] == 4'd0) && keys[vx[3:0]];
  assign busy = (state != S_IDLE);

  always_comb begin
    alu_op = ALU_MOV;
    alu_a  = vx;
    alu_b  = vy;
    if (state == S_EXEC) begin
      if (op == OP_ADDI) begin
        alu_op = ALU_ADD;
      end else if (op == OP_ALU) begin
        alu_op = alu_op_of(ni);
      end
      if (op == OP_SEI || op == OP_SNEI || op == OP_ADDI) begin
        alu_b = nn;
      end
    end else if (state == S_ALU2) begin
      alu_op = alu_op_of(ni);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = req.addr;
    mem_wdata = req.wdata;
    mem_raddr = req.addr;
    fb_we     = 1'b0;
    fb_waddr  = row;
    fb_wdata  = fb_rdata ^ mask;
    fb_raddr  = req.addr[4:0];
    stk_we    = 1'b0;
    stk_waddr = smod(sp);
    stk_wdata = pc;
    stk_raddr = smod(sp + 7'd1);
    vr_we     = 1'b0;
    vr_waddr  = xi;
    vr_wdata  = alu_res;
    vr_raddr  = xi;
    case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = clr;
        mem_wdata = (clr < 12'(FONT_BYTES)) ? font_byte(clr[6:0]) : 8'd0;
        fb_we     = (clr < 12'(DISP_HEIGHT));
        fb_waddr  = clr[4:0];
        fb_wdata  = '0;
        stk_we    = (clr < 12'(STACK_DEPTH));
        stk_waddr = clr[SW-1:0];
        stk_wdata = '0;
        vr_we     = (clr < 12'd16);
        vr_waddr  = clr[3:0];
        vr_wdata  = '0;
      end
      S_DISP: begin
        mem_we   = (mode_t'(req.mode) == MODE_WRITE);
        vr_we    = (mode_t'(req.mode) == MODE_KDOWN) && key_wait;
        vr_waddr = wait_x;
        vr_wdata = {4'd0, req.key_code};
      end
      S_F0: mem_raddr = pc;
      S_F1: mem_raddr = pc + 12'd1;
      S_RX: vr_raddr = (op == OP_JPV) ? 4'd0 : xi;
      S_RY: vr_raddr = yi;
      S_EXEC: begin
        case (op)
          OP_CALL: stk_we = 1'b1;
          OP_LDI: begin
            vr_we    = 1'b1;
            vr_wdata = nn;
          end
          OP_ADDI: vr_we = 1'b1;
          OP_ALU: begin
            vr_we = (ni == 4'h0 || ni == 4'h1 || ni == 4'h2 || ni == 4'h3 ||
                     ni == 4'h4 || ni == 4'h5 || ni == 4'h6 || ni == 4'h7 ||
                     ni == 4'hE);
            if (ni == 4'h4 || ni == 4'h5 || ni == 4'h6 || ni == 4'h7 || ni == 4'hE) begin
              vr_waddr = 4'hF;
              vr_wdata = {7'd0, alu_flag};
            end
          end
          OP_RND: begin
            vr_we    = 1'b1;
            vr_wdata = req.rand_byte & nn;
          end
          OP_MISC: begin
            vr_we    = (nn == FX_GDT);
            vr_wdata = delay_cnt;
          end
          default: vr_we = 1'b0;
        endcase
      end
      S_ALU2: vr_we = 1'b1;
      S_CLS: begin
        fb_we    = 1'b1;
        fb_waddr = cnt;
        fb_wdata = '0;
      end
      S_D0: begin
        mem_raddr = ireg[11:0] + {7'd0, cnt};
        fb_raddr  = ysum[4:0];
        if (!(cnt < {1'b0, ni} && ysum < 9'(DISP_HEIGHT))) begin
          vr_we    = 1'b1;
          vr_waddr = 4'hF;
          vr_wdata = {7'd0, hit};
        end
      end
      S_D1: fb_we = 1'b1;
      S_BW: begin
        mem_we    = 1'b1;
        mem_waddr = ireg[11:0] + {7'd0, cnt};
        mem_wdata = (cnt == 5'd0) ? {6'd0, hd} : (cnt == 5'd1) ? {4'd0, td} : val;
      end
      S_ST0: vr_raddr = cnt[3:0];
      S_ST1: begin
        mem_we    = 1'b1;
        mem_waddr = ireg[11:0] + {7'd0, cnt};
        mem_wdata = vr_rdata;
      end
      S_LD0: mem_raddr = ireg[11:0] + {7'd0, cnt};
      S_LD1: begin
        vr_we    = 1'b1;
        vr_waddr = cnt[3:0];
        vr_wdata = mem_rdata;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      clr       <= '0;
      pc        <= PC_RESET;
      ireg      <= '0;
      sp        <= 7'h7f;
      delay_cnt <= '0;
      sound_cnt <= '0;
      keys      <= '0;
      key_wait  <= 1'b0;
      halt      <= 1'b0;
      wait_x    <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_INIT: begin
          clr <= clr + 12'd1;
          if (clr == 12'(MEM_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            req   <= cmd;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          rd    <= '0;
          state <= S_FIN;
          case (mode_t'(req.mode))
            MODE_EXEC: if (!halt && !key_wait) state <= S_F0;
            MODE_TICK: begin
              if (delay_cnt != 8'd0) delay_cnt <= delay_cnt - 8'd1;
              if (sound_cnt != 8'd0) sound_cnt <= sound_cnt - 8'd1;
            end
            MODE_READ, MODE_ROW: state <= S_RDW;
            MODE_KDOWN: begin
              keys     <= keys | (16'd1 << req.key_code);
              key_wait <= 1'b0;
            end
            MODE_KUP: keys <= keys & ~(16'd1 << req.key_code);
            default: state <= S_FIN;
          endcase
        end
        S_RDW: begin
          rd    <= (mode_t'(req.mode) == MODE_READ) ? {56'd0, mem_rdata} : fb_rdata;
          state <= S_FIN;
        end
        S_FIN: begin
          done                <= 1'b1;
          result.status       <= halt ? ST_HALT : (key_wait ? ST_WAIT : ST_DONE);
          result.prog_counter <= pc;
          result.peek_data    <= rd;
          result.sound_on     <= (sound_cnt != 8'd0);
          state               <= S_IDLE;
        end
        S_F0: state <= S_F1;
        S_F1: begin
          ins_hi <= mem_rdata;
          state  <= S_F2;
        end
        S_F2: begin
          ins_lo <= mem_rdata;
          pc     <= pc + 12'd2;
          state  <= S_RX;
        end
        S_RX: state <= S_RY;
        S_RY: begin
          vx    <= vr_rdata;
          state <= S_RV;
        end
        S_RV: begin
          vy    <= vr_rdata;
          state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_FIN;
          cnt   <= '0;
          hit   <= 1'b0;
          case (op)
            OP_SYS: begin
              if (nn == NN_CLS && xi == 4'd0) begin
                state <= S_CLS;
              end else if (nn == NN_RET && xi == 4'd0) begin
                sp    <= sp + 7'd1;
                state <= S_RET;
              end else begin
                halt <= 1'b1;
              end
            end
            OP_JP: pc <= nnn;
            OP_CALL: begin
              sp <= sp - 7'd1;
              pc <= nnn;
            end
            OP_SEI, OP_SE: if (alu_eq) pc <= pc + 12'd2;
            OP_SNEI, OP_SNE: if (!alu_eq) pc <= pc + 12'd2;
            OP_ALU: begin
              if (ni == 4'h4 || ni == 4'h5 || ni == 4'h6 || ni == 4'h7 || ni == 4'hE) begin
                if (xi == 4'hF) vx <= {7'd0, alu_flag};
                if (yi == 4'hF) vy <= {7'd0, alu_flag};
                state <= S_ALU2;
              end else if (!(ni == 4'h0 || ni == 4'h1 || ni == 4'h2 || ni == 4'h3)) begin
                halt <= 1'b1;
              end
            end
            OP_LDIX: ireg <= {4'd0, nnn};
            OP_JPV: pc <= {4'd0, vx} + nnn;
            OP_DRW: state <= S_D0;
            OP_KEY: begin
              if (nn == NN_SKNP) begin
                if (!key_hit) pc <= pc + 12'd2;
              end else if (nn == NN_SKP) begin
                if (key_hit) pc <= pc + 12'd2;
              end else begin
                halt <= 1'b1;
              end
            end
            OP_MISC: begin
              case (nn)
                FX_GDT: state <= S_FIN;
                FX_SST: sound_cnt <= vx;
                FX_SDT: delay_cnt <= vx;
                FX_ADDI: ireg <= ireg + {8'd0, vx};
                FX_FONT: ireg <= {6'd0, vx, 2'd0} + {8'd0, vx};
                FX_WKEY: begin
                  key_wait <= 1'b1;
                  wait_x   <= xi;
                end
                FX_BCD: begin
                  val   <= vx;
                  hd    <= '0;
                  td    <= '0;
                  state <= S_BH;
                end
                FX_STOR: state <= S_ST0;
                FX_LOAD: state <= S_LD0;
                default: halt <= 1'b1;
              endcase
            end
            default: state <= S_FIN;
          endcase
        end
        S_ALU2: state <= S_FIN;
        S_CLS: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'(DISP_HEIGHT - 1)) state <= S_FIN;
        end
        S_RET: begin
          pc    <= stk_rdata;
          state <= S_FIN;
        end
        S_D0: begin
          row <= ysum[4:0];
          if (cnt < {1'b0, ni} && ysum < 9'(DISP_HEIGHT)) begin
            state <= S_D1;
          end else begin
            state <= S_FIN;
          end
        end
        S_D1: begin
          hit   <= hit | (|(fb_rdata & mask));
          cnt   <= cnt + 5'd1;
          state <= S_D0;
        end
        S_BH: begin
          if (val >= 8'd100) begin
            val <= val - 8'd100;
            hd  <= hd + 2'd1;
          end else begin
            state <= S_BT;
          end
        end
        S_BT: begin
          if (val >= 8'd10) begin
            val <= val - 8'd10;
            td  <= td + 4'd1;
          end else begin
            state <= S_BW;
          end
        end
        S_BW: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd2) state <= S_FIN;
        end
        S_ST0: state <= S_ST1;
        S_ST1: begin
          cnt   <= cnt + 5'd1;
          state <= (cnt[3:0] == xi) ? S_FIN : S_ST0;
        end
        S_LD0: state <= S_LD1;
        S_LD1: begin
          cnt   <= cnt + 5'd1;
          state <= (cnt[3:0] == xi) ? S_FIN : S_LD0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("Result strobe while the sequencer is still busy.");
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("Accepted transfer did not make the block busy.");
  assert property (@(posedge clk) disable iff (rst) done |-> result.status != 2'd3)
    else $error("Undefined status code reported.");
  assert property (@(posedge clk) disable iff (rst) (state == S_INIT) |-> !done)
    else $error("Result produced during the clearing pass.");

endmodule
`default_nettype wire
